### rtl/rtef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtef_pkg: shared definitions for the raw terminal echo FIFO
// Byte and fill widths, field codes, echo character constants and the
// encoded echo descriptor passed from the caret encoder to the top level.
// ----------------------------------------------------------------------------
package rtef_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int FILL_W = 9;

   // Default FIFO depth (entries)
   localparam int FIFO_DEPTH_DEF = 256;

   // Request mode codes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Response kind codes
   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Echo characters
   localparam logic [BYTE_W-1:0] CARET_CHAR   = 8'h5E;
   localparam logic [BYTE_W-1:0] CARET_OFFSET = 8'h40;
   localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_BS        = 8'h08;
   localparam logic [BYTE_W-1:0] PRINT_LO     = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI     = 8'h7E;
   localparam logic [BYTE_W-1:0] HIGH_LO      = 8'h80;
   localparam logic [BYTE_W-1:0] HIGH_HI      = 8'hFF;

   // Echo descriptor for one written byte
   typedef struct packed {
      logic              caret;   // two-beat caret pair
      logic [BYTE_W-1:0] first;   // first echo beat
      logic [BYTE_W-1:0] second;  // second echo beat (caret pair only)
   } echo_enc_type;

endpackage

### rtl/rtef_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtef channel interfaces
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------
interface rtef_req_if;
   import rtef_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [BYTE_W-1:0] data_byte;
   logic              final_byte;

   modport source (output valid, mode, data_byte, final_byte, input ready);
   modport sink   (input valid, mode, data_byte, final_byte, output ready);
endinterface

interface rtef_rsp_if;
   import rtef_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] out_byte;
   logic              read_valid;
   logic              last;
   logic [FILL_W-1:0] fill_level;

   modport source (output valid, kind, out_byte, read_valid, last, fill_level,
                   input ready);
   modport sink   (input valid, kind, out_byte, read_valid, last, fill_level,
                   output ready);
endinterface

interface rtef_csr_if;
   logic valid;
   logic ready;
   logic echo_enable;

   modport source (output valid, echo_enable, input ready);
   modport sink   (input valid, echo_enable, output ready);
endinterface

### rtl/rtef_caret.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtef_caret: echo encoder
// Classifies a written byte and builds its echo beats: the byte itself for
// printable, high, LF, CR and BS bytes, otherwise '^' then byte + 0x40.
// ----------------------------------------------------------------------------
module rtef_caret (
   input  logic [rtef_pkg::BYTE_W-1:0] data_byte,
   output rtef_pkg::echo_enc_type      enc
);
   import rtef_pkg::*;

   logic plain;

   // Classify the byte
   always_comb begin
      case (data_byte) inside
         [PRINT_LO:PRINT_HI], [HIGH_LO:HIGH_HI], CH_LF, CH_CR, CH_BS: plain = 1'b1;
         default: plain = 1'b0;
      endcase
   end

   // Build echo beats
   always_comb begin
      enc.caret  = ~plain;
      enc.first  = plain ? data_byte : CARET_CHAR;
      enc.second = data_byte + CARET_OFFSET;
   end

endmodule

### rtl/raw_terminal_echo_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_terminal_echo_fifo: raw-mode terminal byte FIFO with console echo
// Write beats push a byte into a circular FIFO (dropped when full) and, with
// echo on, return the echo character or a '^' caret pair. Read beats pop the
// oldest byte or report empty.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    mode, data_byte, final_byte
//   rsp_bus   out  valid/ready    kind, out_byte, read_valid, last, fill_level
//   csr_bus   in   valid/ready    echo_enable (ready always high)
//
// Cycles: one request beat per cycle while the output register can take it;
// FIFO state updates at the accept edge and the response appears from the
// output register in the next cycle. A caret pair holds the output register
// for two response beats, so the request after it waits for the second beat.
// Stalls: a request is taken while the output register is empty or its last
// beat is leaving. Writes with echo off produce no response.
// Reset: pointers and count clear, echo turns on; storage is not cleared.
// ----------------------------------------------------------------------------
module raw_terminal_echo_fifo #(
   parameter int FIFO_DEPTH = rtef_pkg::FIFO_DEPTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rtef_req_if.sink   req_bus,
   rtef_rsp_if.source rsp_bus,
   rtef_csr_if.sink   csr_bus
);
   import rtef_pkg::*;

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   // FIFO state
   logic [BYTE_W-1:0] mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] rd_q_ff;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              echo_ff, echo_in;

   // Output register
   logic              s1_valid_ff, s1_valid_in;
   logic              pair_ff, pair_in;
   logic              kind_ff, kind_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [BYTE_W-1:0] second_ff, second_in;
   logic              rvalid_ff, rvalid_in;
   logic              from_mem_ff, from_mem_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic         req_fire, rsp_fire, rsp_done;
   logic         is_wr, push, pop, emit;
   echo_enc_type enc;

   rtef_caret u_caret (
      .data_byte (req_bus.data_byte),
      .enc       (enc)
   );

   // Handshakes
   assign csr_bus.ready = 1'b1;
   assign rsp_fire      = rsp_bus.valid & rsp_bus.ready;
   assign rsp_done      = rsp_fire & ~pair_ff;
   assign req_bus.ready = ~s1_valid_ff | rsp_done;
   assign req_fire      = req_bus.valid & req_bus.ready;

   // Decode the accepted beat
   assign is_wr = (req_bus.mode == MODE_WRITE);
   assign push  = req_fire & is_wr & (count_ff != CW'(FIFO_DEPTH));
   assign pop   = req_fire & ~is_wr & (count_ff != '0);
   assign emit  = req_fire & (~is_wr | echo_ff);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // Latch the echo enable
   assign echo_in = (csr_bus.valid & csr_bus.ready) ? csr_bus.echo_enable : echo_ff;

   // Load or advance the output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      pair_in     = pair_ff;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      second_in   = second_ff;
      rvalid_in   = rvalid_ff;
      from_mem_in = from_mem_ff;
      fill_in     = fill_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
         fill_in     = FILL_W'(count_in);
         second_in   = enc.second;
         if (is_wr) begin
            kind_in     = KIND_ECHO;
            pair_in     = enc.caret;
            byte_in     = enc.first;
            rvalid_in   = 1'b0;
            from_mem_in = 1'b0;
         end else begin
            kind_in     = KIND_READ;
            pair_in     = 1'b0;
            byte_in     = '0;
            rvalid_in   = pop;
            from_mem_in = pop;
         end
      end else if (rsp_fire && pair_ff) begin
         pair_in = 1'b0;
         byte_in = second_ff;
      end else if (rsp_done) begin
         s1_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         echo_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
         pair_ff     <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         echo_ff     <= echo_in;
         s1_valid_ff <= s1_valid_in;
         pair_ff     <= pair_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      second_ff   <= second_in;
      rvalid_ff   <= rvalid_in;
      from_mem_ff <= from_mem_in;
      fill_ff     <= fill_in;
   end

   // Byte storage: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= req_bus.data_byte;
      end
      if (pop) begin
         rd_q_ff <= mem[rd_ptr_ff];
      end
   end

   // Drive the response beat
   assign rsp_bus.valid      = s1_valid_ff;
   assign rsp_bus.kind       = kind_ff;
   assign rsp_bus.out_byte   = from_mem_ff ? rd_q_ff : byte_ff;
   assign rsp_bus.read_valid = rvalid_ff;
   assign rsp_bus.last       = ~pair_ff;
   assign rsp_bus.fill_level = fill_ff;

endmodule

### rtl/rtef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtef_checker: port-level checks for the raw terminal echo FIFO
// Watches the response channel for handshake and caret-pair ordering rules.
// ----------------------------------------------------------------------------
module rtef_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_kind,
   input logic [rtef_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_last
);
   import rtef_pkg::*;

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // Start empty after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A non-final beat is the caret of an echo pair
   a_caret_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_ECHO && rsp_out_byte == CARET_CHAR)
      else $error("non-final beat is not a caret");

   // The second half of a caret pair follows at once and closes the item
   a_caret_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last
                                           && rsp_kind == KIND_ECHO)
      else $error("caret pair not completed");

endmodule

bind raw_terminal_echo_fifo rtef_checker u_rtef_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.kind),
   .rsp_out_byte (rsp_bus.out_byte),
   .rsp_last     (rsp_bus.last)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for raw_terminal_echo_fifo
// Drives write and read beats into the terminal FIFO and compares every
// response beat against a local prediction of the echo encoder and the byte
// queue or, for most rows of the directed table that comes first, against
// hand-typed results. Random phases then toggle echo, fill the queue past
// its depth and drain it. Both sides idle at random, and the console side
// holds off once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module testbench;
   import rtef_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 9;
   localparam int DEPTH         = FIFO_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PCT      = 16;
   localparam int PREDICT       = -1;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

   // one response beat as it leaves the block
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] out_byte;
      logic              read_valid;
      logic              last;
      logic [FILL_W-1:0] fill_level;
   } tty_beat_type;

   typedef enum logic {ROW_ITEM, ROW_ECHO_CFG} row_kind_type;

   // directed stimulus row; for echo rows, data bit 0 holds the enable
   typedef struct {
      row_kind_type      kind;
      logic              mode;
      logic [BYTE_W-1:0] data;
      logic              fin;
      int                n_typed;
      tty_beat_type      typed0;
      tty_beat_type      typed1;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   rtef_req_if req_bus ();
   rtef_rsp_if rsp_bus ();
   rtef_csr_if csr_bus ();

   raw_terminal_echo_fifo DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted terminal state
   logic [BYTE_W-1:0] tty_store [DEPTH];
   int                tty_wr_pos;
   int                tty_held;
   logic              echo_on;

   tty_beat_type tty_expect_q [$];
   dir_row_type  dir_rows [$];
   int           mismatches;
   logic         calm;
   logic         hold_rsp;

   always #(HALF_PERIOD) clock = ~clock;

   // Predict the beats one accepted request causes and advance the state.
   function automatic int tty_predict(input logic mode, input logic [BYTE_W-1:0] b,
                                      output tty_beat_type r0, output tty_beat_type r1);
      logic plain;
      r0 = '0;
      r1 = '0;
      if (mode == MODE_WRITE) begin
         if (tty_held < DEPTH) begin
            tty_store[tty_wr_pos] = b;
            tty_wr_pos = (tty_wr_pos + 1) % DEPTH;
            tty_held++;
         end
         if (!echo_on) return 0;
         plain = (b >= PRINT_LO && b <= PRINT_HI) || b >= HIGH_LO ||
                 b == CH_LF || b == CH_CR || b == CH_BS;
         if (plain) begin
            r0 = {KIND_ECHO, b, 1'b0, 1'b1, FILL_W'(tty_held)};
            return 1;
         end
         r0 = {KIND_ECHO, CARET_CHAR, 1'b0, 1'b0, FILL_W'(tty_held)};
         r1 = {KIND_ECHO, b + CARET_OFFSET, 1'b0, 1'b1, FILL_W'(tty_held)};
         return 2;
      end
      if (tty_held == 0) begin
         r0 = {KIND_READ, 8'h00, 1'b0, 1'b1, FILL_W'(0)};
         return 1;
      end
      r0.out_byte = tty_store[(tty_wr_pos + DEPTH - tty_held) % DEPTH];
      tty_held--;
      r0.kind       = KIND_READ;
      r0.read_valid = 1'b1;
      r0.last       = 1'b1;
      r0.fill_level = FILL_W'(tty_held);
      return 1;
   endfunction

   function automatic tty_beat_type mk_beat(input logic kind, input logic [BYTE_W-1:0] b,
                                            input int rv, input int last, input int fill);
      return {kind, b, 1'(rv), 1'(last), FILL_W'(fill)};
   endfunction

   function automatic void add_row(input row_kind_type k, input logic mode,
                                   input logic [BYTE_W-1:0] b, input logic fin,
                                   input int n, input tty_beat_type e0 = '0,
                                   input tty_beat_type e1 = '0);
      dir_row_type row;
      row.kind    = k;
      row.mode    = mode;
      row.data    = b;
      row.fin     = fin;
      row.n_typed = n;
      row.typed0  = e0;
      row.typed1  = e1;
      dir_rows.push_back(row);
   endfunction

   // Bias bytes toward the caret range and the pass-through control codes.
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(9))
         0, 1, 2: return BYTE_W'($urandom_range(31));
         3: begin
            case ($urandom_range(3))
               0: return CH_LF;
               1: return CH_CR;
               2: return CH_BS;
               default: return CH_DEL;
            endcase
         end
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one request beat, with an occasional gap, until it is taken.
   task automatic send_beat(input logic mode, input logic [BYTE_W-1:0] b, input logic fin);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.data_byte  <= b;
      req_bus.final_byte <= fin;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Send a beat and queue its results, typed in or predicted.
   task automatic issue_item(input logic mode, input logic [BYTE_W-1:0] b, input logic fin,
                             input int n_typed, input tty_beat_type e0,
                             input tty_beat_type e1);
      tty_beat_type r0;
      tty_beat_type r1;
      int           n;
      send_beat(mode, b, fin);
      n = tty_predict(mode, b, r0, r1);
      if (n_typed != PREDICT) begin
         n  = n_typed;
         r0 = e0;
         r1 = e1;
      end
      if (n > 0) tty_expect_q.push_back(r0);
      if (n > 1) tty_expect_q.push_back(r1);
   endtask

   // Drop valid, wait for every expected beat, then let the pipe empty.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (tty_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_echo(input logic en);
      settle_idle();
      csr_bus.valid       <= 1'b1;
      csr_bus.echo_enable <= en;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      echo_on = en;
   endtask

   task automatic run_random(input int count, input int write_pct);
      logic mode;
      for (int i = 0; i < count; i++) begin
         mode = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
         issue_item(mode, pick_byte(), 1'($urandom_range(1)), PREDICT, '0, '0);
      end
   endtask

   // Console side: random ready, one long hold-off on request.
   initial begin : rsp_ready_drive
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      tty_beat_type got;
      tty_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.kind, rsp_bus.out_byte, rsp_bus.read_valid, rsp_bus.last,
                rsp_bus.fill_level};
         if (tty_expect_q.size() == 0) begin
            $display("%0t: unexpected beat kind=%0d byte=%02h valid=%0d last=%0d fill=%0d",
                     $time, got.kind, got.out_byte, got.read_valid, got.last,
                     got.fill_level);
            mismatches++;
         end else begin
            want = tty_expect_q.pop_front();
            if (got !== want) begin
               $display("%0t: beat mismatch expected kind=%0d byte=%02h valid=%0d last=%0d fill=%0d",
                        $time, want.kind, want.out_byte, want.read_valid, want.last,
                        want.fill_level);
               $display("%0t:                 actual kind=%0d byte=%02h valid=%0d last=%0d fill=%0d",
                        $time, got.kind, got.out_byte, got.read_valid, got.last,
                        got.fill_level);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   initial begin : run_limit
      #1_000_000;
      $display("raw_terminal_echo_fifo test failed");
      $finish;
   end

   initial begin : stimulus
      mismatches = 0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      tty_wr_pos = 0;
      tty_held   = 0;
      echo_on    = 1'b1;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= MODE_WRITE;
      req_bus.data_byte   <= '0;
      req_bus.final_byte  <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.echo_enable <= 1'b0;

      // Directed table: empty read, echo classes, caret pairs, echo off
      add_row(ROW_ITEM, MODE_READ,  8'h00, 1'b0, 1, mk_beat(KIND_READ, 8'h00, 0, 1, 0));
      add_row(ROW_ITEM, MODE_WRITE, 8'h41, 1'b0, 1, mk_beat(KIND_ECHO, 8'h41, 0, 1, 1));
      add_row(ROW_ITEM, MODE_WRITE, 8'h20, 1'b1, 1, mk_beat(KIND_ECHO, 8'h20, 0, 1, 2));
      add_row(ROW_ITEM, MODE_WRITE, 8'h7E, 1'b0, 1, mk_beat(KIND_ECHO, 8'h7E, 0, 1, 3));
      add_row(ROW_ITEM, MODE_WRITE, CH_DEL, 1'b0, 2,
              mk_beat(KIND_ECHO, CARET_CHAR, 0, 0, 4), mk_beat(KIND_ECHO, 8'hBF, 0, 1, 4));
      add_row(ROW_ITEM, MODE_WRITE, 8'h00, 1'b0, 2,
              mk_beat(KIND_ECHO, CARET_CHAR, 0, 0, 5), mk_beat(KIND_ECHO, 8'h40, 0, 1, 5));
      add_row(ROW_ITEM, MODE_WRITE, 8'h1F, 1'b1, 2,
              mk_beat(KIND_ECHO, CARET_CHAR, 0, 0, 6), mk_beat(KIND_ECHO, 8'h5F, 0, 1, 6));
      add_row(ROW_ITEM, MODE_WRITE, 8'h80, 1'b0, 1, mk_beat(KIND_ECHO, 8'h80, 0, 1, 7));
      add_row(ROW_ITEM, MODE_WRITE, 8'hFF, 1'b0, 1, mk_beat(KIND_ECHO, 8'hFF, 0, 1, 8));
      add_row(ROW_ITEM, MODE_WRITE, CH_LF, 1'b0, 1, mk_beat(KIND_ECHO, CH_LF, 0, 1, 9));
      add_row(ROW_ITEM, MODE_WRITE, CH_CR, 1'b0, 1, mk_beat(KIND_ECHO, CH_CR, 0, 1, 10));
      add_row(ROW_ITEM, MODE_WRITE, CH_BS, 1'b0, 1, mk_beat(KIND_ECHO, CH_BS, 0, 1, 11));
      add_row(ROW_ITEM, MODE_WRITE, 8'h09, 1'b0, 2,
              mk_beat(KIND_ECHO, CARET_CHAR, 0, 0, 12), mk_beat(KIND_ECHO, 8'h49, 0, 1, 12));
      add_row(ROW_ITEM, MODE_WRITE, 8'h1B, 1'b1, PREDICT);
      add_row(ROW_ITEM, MODE_READ,  8'hFF, 1'b0, 1, mk_beat(KIND_READ, 8'h41, 1, 1, 12));
      add_row(ROW_ITEM, MODE_READ,  8'h00, 1'b1, PREDICT);
      add_row(ROW_ECHO_CFG, MODE_WRITE, 8'h00, 1'b0, 0);
      add_row(ROW_ITEM, MODE_WRITE, 8'h00, 1'b1, 0);
      add_row(ROW_ITEM, MODE_WRITE, 8'h55, 1'b1, 0);
      add_row(ROW_ITEM, MODE_READ,  8'hAA, 1'b0, PREDICT);
      add_row(ROW_ECHO_CFG, MODE_WRITE, 8'h01, 1'b0, 0);
      add_row(ROW_ITEM, MODE_READ,  8'h00, 1'b1, PREDICT);

      // hold reset, then release
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_ECHO_CFG) begin
            set_echo(dir_rows[i].data[0]);
         end else begin
            issue_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].fin,
                       dir_rows[i].n_typed, dir_rows[i].typed0, dir_rows[i].typed1);
         end
      end

      // mixed traffic with echo on while the console stalls
      hold_rsp = 1'b1;
      run_random(20, 55);

      // echo off: push past the depth so writes get dropped
      set_echo(1'b0);
      run_random(250, 100);

      // echo on against a full queue
      set_echo(1'b1);
      run_random(20, 80);

      // drain with no idling on either side
      calm = 1'b1;
      run_random(240, 5);
      calm = 1'b0;

      settle_idle();
      if (mismatches == 0) begin
         $display("raw_terminal_echo_fifo test passed");
      end else begin
         $display("raw_terminal_echo_fifo test failed");
      end
      $finish;
   end

endmodule

### raw_terminal_echo_fifo.f
rtl/rtef_pkg.sv
rtl/rtef_chan_if.sv
rtl/rtef_caret.sv
rtl/raw_terminal_echo_fifo.sv
rtl/rtef_checker.sv
sim/testbench.sv
